// ----- sv/ptb_pkg.sv -----
// Shared constants, codes and types of the periodic timer bank.
package ptb_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NREP_W = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] KIND_REGISTER   = 3'd0;
    localparam logic [2:0] KIND_REMOVE     = 3'd1;
    localparam logic [2:0] KIND_TICK       = 3'd2;
    localparam logic [2:0] KIND_PAUSE      = 3'd3;
    localparam logic [2:0] KIND_RESUME     = 3'd4;
    localparam logic [2:0] KIND_SET_PERIOD = 3'd5;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

    typedef logic [SLOT_W-1:0]      t_slot;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        t_count period;
        t_count count;
    } t_slot_data;

    typedef struct packed {
        logic       en;
        t_slot      addr;
        t_slot_data data;
    } t_mem_wr;

    typedef struct packed {
        logic  en;
        t_slot addr;
    } t_mem_rd;

    typedef struct packed {
        logic [3:0] id;
        logic       fired;
        logic [1:0] status;
        logic       last;
    } t_result;

endpackage

// ----- sv/ptb_slot_mem.sv -----
// Period and count memory of the timer slots, one write and one registered read port.
module ptb_slot_mem (
    input  logic                i_clk,
    input  ptb_pkg::t_mem_wr    i_wr,
    input  ptb_pkg::t_mem_rd    i_rd,
    output ptb_pkg::t_slot_data o_rd_data
);
    import ptb_pkg::*;

    t_slot_data r_mem [NUM_SLOTS];
    t_slot_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/periodic_timer_bank_core.sv -----
// Top level of the periodic timer bank: command sequencer, slot flags and tick walk.
//
//   Channel   Signals                                      Transfer when
//   input     i_in_valid, o_in_ready, kind/slot_id/period   i_in_valid && o_in_ready
//   output    o_out_valid, i_out_ready, result fields       o_out_valid && i_out_ready
//
// Remove, pause, resume and set interval pass the command state, then the emit state, which loads the result.
// Register walks one slot a cycle from the allocation pointer, checking up to NUM_SLOTS slots.
// Tick walks every slot: an idle slot passes the read state only, a live one takes a memory read, then
// a write back; the end state and then the emit state close the walk.
// The input is ready again as soon as the final result is loaded into the output register.
// Reset is synchronous and clears all flags and the allocation pointer; the memory needs no pass.
// A busy output holds the final result and stalls the tick walk when a firing pushes a result.
module periodic_timer_bank_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_slot_id,
    input  logic [15:0] i_period,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_result_id,
    output logic       o_fired,
    output logic [1:0] o_status,
    output logic       o_last
);
    import ptb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMD,
        ST_TICK_RD,
        ST_TICK_WB,
        ST_TICK_END,
        ST_EMIT
    } t_state;

    t_state                r_state;
    logic [2:0]            r_kind;
    logic [3:0]            r_sid;
    t_count                r_period;
    t_slot                 r_idx;
    t_slot                 r_cnt;
    logic [NREP_W-1:0]     r_nrep;
    t_slot                 r_pend_id;
    logic [NUM_SLOTS-1:0]  r_valid;
    logic [NUM_SLOTS-1:0]  r_paused;
    t_slot                 r_next_alloc;
    t_result               r_res;
    t_result               r_out;
    logic                  r_out_valid;

    t_mem_wr    w_mem_wr;
    t_mem_rd    w_mem_rd;
    t_slot_data w_rd_data;

    t_slot  w_sid_slot;
    logic   w_sid_ok;
    logic   w_idx_last;
    t_slot  w_idx_next;
    logic   w_live;
    t_count w_dec;
    logic   w_fire;
    logic   w_report;
    logic   w_out_free;
    logic   w_stall;
    logic   w_out_load;

    assign w_sid_slot = t_slot'(r_sid);
    assign w_sid_ok   = (int'(r_sid) < NUM_SLOTS) && r_valid[w_sid_slot];
    assign w_idx_last = (r_idx == t_slot'(NUM_SLOTS - 1));
    assign w_idx_next = w_idx_last ? '0 : t_slot'(r_idx + 1'b1);
    assign w_live     = r_valid[r_idx] && !r_paused[r_idx];
    assign w_dec      = t_count'(w_rd_data.count - 1'b1);
    assign w_fire     = (w_dec == '0);
    assign w_report   = w_fire && (r_nrep < NREP_W'(MAX_RESULTS));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_stall    = w_report && (r_nrep != '0) && !w_out_free;
    assign w_out_load = ((r_state == ST_EMIT) && w_out_free) ||
                        ((r_state == ST_TICK_WB) && !w_stall && w_report && (r_nrep != '0));

    always_comb begin
        w_mem_rd.en   = (r_state == ST_TICK_RD) && w_live;
        w_mem_rd.addr = r_idx;

        w_mem_wr.en          = 1'b0;
        w_mem_wr.addr        = r_idx;
        w_mem_wr.data.period = r_period;
        w_mem_wr.data.count  = r_period;
        case (r_state)
            ST_SEARCH: begin
                w_mem_wr.en = !r_valid[r_idx];
            end
            ST_CMD: begin
                w_mem_wr.en   = (r_kind == KIND_SET_PERIOD) && w_sid_ok;
                w_mem_wr.addr = w_sid_slot;
            end
            ST_TICK_WB: begin
                w_mem_wr.en          = !w_stall;
                w_mem_wr.data.period = w_rd_data.period;
                w_mem_wr.data.count  = w_fire ? w_rd_data.period : w_dec;
            end
            default: begin
                w_mem_wr.en = 1'b0;
            end
        endcase
    end

    ptb_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_wr      (w_mem_wr),
        .i_rd      (w_mem_rd),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_valid      <= '0;
            r_paused     <= '0;
            r_next_alloc <= '0;
            r_nrep       <= '0;
        end else begin
            if (r_out_valid && i_out_ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_kind   <= i_kind;
                        r_sid    <= i_slot_id;
                        r_period <= t_count'(i_period);
                        case (i_kind)
                            KIND_REGISTER: begin
                                r_idx   <= r_next_alloc;
                                r_cnt   <= '0;
                                r_state <= ST_SEARCH;
                            end
                            KIND_TICK: begin
                                r_idx   <= '0;
                                r_nrep  <= '0;
                                r_state <= ST_TICK_RD;
                            end
                            default: begin
                                r_state <= ST_CMD;
                            end
                        endcase
                    end
                end
                ST_SEARCH: begin
                    if (!r_valid[r_idx]) begin
                        r_valid[r_idx]  <= 1'b1;
                        r_paused[r_idx] <= 1'b0;
                        r_next_alloc    <= w_idx_next;
                        r_res           <= '{id: 4'(r_idx), fired: 1'b0,
                                             status: STATUS_OK, last: 1'b1};
                        r_state         <= ST_EMIT;
                    end else if (r_cnt == t_slot'(NUM_SLOTS - 1)) begin
                        r_res   <= '{id: 4'd0, fired: 1'b0, status: STATUS_FULL, last: 1'b1};
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx <= w_idx_next;
                        r_cnt <= t_slot'(r_cnt + 1'b1);
                    end
                end
                ST_CMD: begin
                    r_state <= ST_EMIT;
                    case (r_kind)
                        KIND_REMOVE, KIND_PAUSE, KIND_RESUME, KIND_SET_PERIOD: begin
                            r_res <= '{id: r_sid, fired: 1'b0,
                                       status: w_sid_ok ? STATUS_OK : STATUS_NO_SLOT,
                                       last: 1'b1};
                            if (w_sid_ok && r_kind == KIND_REMOVE) begin
                                r_valid[w_sid_slot]  <= 1'b0;
                                r_paused[w_sid_slot] <= 1'b0;
                            end else if (w_sid_ok && r_kind == KIND_PAUSE) begin
                                r_paused[w_sid_slot] <= 1'b1;
                            end else if (w_sid_ok && r_kind == KIND_RESUME) begin
                                r_paused[w_sid_slot] <= 1'b0;
                            end
                        end
                        default: begin
                            r_res <= '{id: 4'd0, fired: 1'b0, status: STATUS_OK, last: 1'b1};
                        end
                    endcase
                end
                ST_TICK_RD: begin
                    if (w_live) begin
                        r_state <= ST_TICK_WB;
                    end else if (w_idx_last) begin
                        r_state <= ST_TICK_END;
                    end else begin
                        r_idx <= w_idx_next;
                    end
                end
                ST_TICK_WB: begin
                    if (!w_stall) begin
                        if (w_report) begin
                            if (r_nrep != '0) begin
                                r_out       <= '{id: 4'(r_pend_id), fired: 1'b1,
                                                 status: STATUS_OK, last: 1'b0};
                                r_out_valid <= 1'b1;
                            end
                            r_pend_id <= r_idx;
                            r_nrep    <= NREP_W'(r_nrep + 1'b1);
                        end
                        if (w_idx_last) begin
                            r_state <= ST_TICK_END;
                        end else begin
                            r_idx   <= w_idx_next;
                            r_state <= ST_TICK_RD;
                        end
                    end
                end
                ST_TICK_END: begin
                    if (r_nrep != '0) begin
                        r_res <= '{id: 4'(r_pend_id), fired: 1'b1, status: STATUS_OK, last: 1'b1};
                    end else begin
                        r_res <= '{id: 4'd0, fired: 1'b0, status: STATUS_OK, last: 1'b1};
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result_id = r_out.id;
    assign o_fired     = r_out.fired;
    assign o_status    = r_out.status;
    assign o_last      = r_out.last;

`ifndef NO_ASSERTIONS
    a_nrep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nrep <= NREP_W'(MAX_RESULTS))
        else $error("tick result count exceeds its limit");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_wr.en && w_mem_rd.en && (w_mem_wr.addr == w_mem_rd.addr)))
        else $error("slot memory read and write hit the same entry");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready while a command is in progress");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_fired) |-> o_last)
        else $error("non-fired result not marked last");

    a_wb_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK_WB) |-> ($past(w_mem_rd.en) || $past(r_state == ST_TICK_WB)))
        else $error("write back without a memory read");
`endif

endmodule
